>>> src/frml_pkg.sv
// Shared constants for the frame rate meter and limiter.
`default_nettype none
package frml_pkg;

    // Number of intervals kept for the moving average
    localparam int WINDOW = 10;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int IVAL_W   = 16;
    localparam int FPS_W    = 22;
    localparam int DELAY_W  = 10;
    localparam int MAXFPS_W = 10;

    // Ring bookkeeping widths
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);

    // Rate math: fps_q8 = FPS_SCALE * count / sum
    localparam int FPS_SCALE   = 256000;
    localparam int MS_PER_S    = 1000;
    localparam int FPS_DEFAULT = 15360;
    localparam int FPS_MAX     = 4194303;

    // Serial divider widths: numerator covers both divisions
    localparam int NUM_RAW_W = $clog2(FPS_SCALE * WINDOW + 1);
    localparam int NUM_W     = (NUM_RAW_W > FPS_W) ? NUM_RAW_W : FPS_W;
    localparam int DEN_W     = (SUM_W > MAXFPS_W) ? SUM_W : MAXFPS_W;
    localparam int DCNT_W    = $clog2(NUM_W + 1);

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIVB = 3'd3;
    localparam logic [2:0] ST_DIVF = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Divider handshake
    typedef struct packed {
        logic start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage
`default_nettype wire

>>> src/frame_rate_meter_limiter_top.sv
// Top level of the frame rate meter and limiter.
//
//  Channel  | Signals                          | Contents
//  ---------+----------------------------------+------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser| tuser: kind; tdata: now_ms
//  m_axis   | m_tvalid m_tready m_tdata        | fps_q8, delay_ms, frame_time_ms
//  config   | cfg_we cfg_wdata                 | max_fps
//
// A frame begin only stores its time stamp. A frame end runs two passes of
// the bit-serial divider, one for the frame budget and one for the average
// rate.
// Reset clears the ring bookkeeping and begin time and sets max_fps to 60.
// A finished result waits in the output register; the next item is taken
// while it waits, and only a second result stalls behind it.
`default_nettype none
module frame_rate_meter_limiter_top
    import frml_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TIME_W-1:0]   s_tdata,   // now_ms
    input  wire logic                s_tuser,   // kind
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [47:0]              m_tdata,   // fps_q8, delay_ms, frame_time_ms
    input  wire logic                cfg_we,
    input  wire logic [MAXFPS_W-1:0] cfg_wdata
);

    logic [2:0]          state_reg, state_next;
    logic [MAXFPS_W-1:0] max_fps_reg;
    logic [TIME_W-1:0]   begin_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   prev_end_reg;
    logic                have_prev_reg;
    logic [IVAL_W-1:0]   ival_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [DELAY_W-1:0]  budget_reg;
    logic                out_valid_reg;
    logic [47:0]         out_data_reg;

    logic                accept;
    logic                out_free;
    logic [TIME_W-1:0]   ival_raw;
    logic [SUM_W-1:0]    ring_sum;
    logic [CNT_W-1:0]    ring_count;
    div_req_t            div_req;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic [FPS_W-1:0]    fps_val;
    logic [DELAY_W-1:0]  delay_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign ival_raw = now_reg - prev_end_reg;

    frml_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (state_reg == ST_UPD),
        .wr_data (ival_reg),
        .sum     (ring_sum),
        .count   (ring_count)
    );

    // Divider operands: budget pass first, then the rate pass
    always_comb
    begin
        div_req.start = (state_reg == ST_UPD) || (state_reg == ST_DIVB && div_done);
        if (state_reg == ST_UPD)
        begin
            div_req.num = NUM_W'(MS_PER_S);
            div_req.den = (max_fps_reg == '0) ? DEN_W'(1) : DEN_W'(max_fps_reg);
        end
        else
        begin
            div_req.num = NUM_W'(FPS_SCALE) * NUM_W'(ring_count);
            div_req.den = DEN_W'(ring_sum);
        end
    end

    frml_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Result fields
    always_comb
    begin
        if (ring_sum == '0)
        begin
            fps_val = FPS_W'(FPS_DEFAULT);
        end
        else if (div_quo > NUM_W'(FPS_MAX))
        begin
            fps_val = FPS_W'(FPS_MAX);
        end
        else
        begin
            fps_val = div_quo[FPS_W-1:0];
        end
        if (TIME_W'(budget_reg) > elapsed_reg)
        begin
            delay_val = budget_reg - elapsed_reg[DELAY_W-1:0];
        end
        else
        begin
            delay_val = '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: state_next = ST_UPD;
            ST_UPD:  state_next = ST_DIVB;
            ST_DIVB:
            begin
                if (div_done)
                begin
                    state_next = ST_DIVF;
                end
            end
            ST_DIVF:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and registers with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_fps_reg   <= MAXFPS_W'(60);
            begin_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_fps_reg <= cfg_wdata;
            end
            if (accept && !s_tuser)
            begin
                begin_reg <= s_tdata;
            end
            if (state_reg == ST_CALC)
            begin
                have_prev_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= s_tdata;
        end
        if (state_reg == ST_CALC)
        begin
            prev_end_reg <= now_reg;
            elapsed_reg  <= now_reg - begin_reg;
            if (!have_prev_reg)
            begin
                ival_reg <= '0;
            end
            else if (ival_raw > TIME_W'(65535))
            begin
                ival_reg <= '1;
            end
            else
            begin
                ival_reg <= ival_raw[IVAL_W-1:0];
            end
        end
        if (state_reg == ST_DIVB && div_done)
        begin
            budget_reg <= div_quo[DELAY_W-1:0];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= {ival_reg, delay_val, fps_val};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

>>> src/frml_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
`default_nettype none
module frml_div
    import frml_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    // One trial subtraction per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.num;
            den_next = req.den;
            cnt_next = DCNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
            end
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> src/frml_ring.sv
// Ring of recent frame intervals with running sum and fill count.
`default_nettype none
module frml_ring
    import frml_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IVAL_W-1:0] wr_data,
    output logic [SUM_W-1:0]       sum,
    output logic [CNT_W-1:0]       count
);

    logic [IVAL_W-1:0] entry_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              full;
    logic [IVAL_W-1:0] old_val;

    // Running sum drops the overwritten entry once the ring is full
    always_comb
    begin
        full      = (fill_reg == CNT_W'(WINDOW));
        old_val   = full ? entry_reg[slot_reg] : '0;
        slot_next = slot_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (wr_en)
        begin
            sum_next  = sum_reg + SUM_W'(wr_data) - SUM_W'(old_val);
            slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            if (!full)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    // Interval storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[slot_reg] <= wr_data;
        end
    end

    assign sum   = sum_reg;
    assign count = fill_reg;

endmodule
`default_nettype wire

>>> dv/frame_rate_meter_limiter_top_test.sv
// Self-checking testbench for the frame rate meter and limiter top level.
module frame_rate_meter_limiter_top_test
    import frml_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Event kinds carried on s_tuser
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // Rate math of the meter
    localparam longint unsigned RATE_SCALE   = 256000;
    localparam longint unsigned RATE_IDLE_Q8 = 15360;
    localparam longint unsigned RATE_CEIL_Q8 = 4194303;
    localparam int unsigned     MS_IN_S      = 1000;

    // Timing of the bench
    localparam int SETTLE_CYCLES = 80;    // quiet cycles before a max_fps write
    localparam int STALL_CYCLES  = 600;   // long receiver hold-off
    localparam int IDLE_PCT      = 37;
    localparam int WATCHDOG_MAX  = 5000;  // cycles with no transfer at all

    typedef enum logic [1:0] {STEP_EVENT, STEP_CONFIG, STEP_DRAIN} step_op_t;

    typedef struct {
        step_op_t            op;
        logic                kind;
        logic [TIME_W-1:0]   now_ms;
        logic [MAXFPS_W-1:0] max_fps;
    } stim_step_t;

    typedef struct packed {
        logic [IVAL_W-1:0]  frame_time_ms;
        logic [DELAY_W-1:0] delay_ms;
        logic [FPS_W-1:0]   fps_q8;
    } frame_report_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TIME_W-1:0]   s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [47:0]         m_tdata;
    logic                cfg_we    = 1'b0;
    logic [MAXFPS_W-1:0] cfg_wdata = '0;

    stim_step_t    step_q[$];
    frame_report_t report_q[$];

    int n_events  = 0;
    int sent_cnt  = 0;
    int got_cnt   = 0;
    int err_cnt   = 0;
    int settle_cnt = 0;

    // Predictor state
    logic [IVAL_W-1:0]   ival_ring[WINDOW];
    int                  ring_wr;
    int                  ring_fill;
    logic [TIME_W-1:0]   last_end_ms;
    bit                  seen_end;
    logic [TIME_W-1:0]   begin_ms;
    logic [MAXFPS_W-1:0] fps_limit;

    frame_rate_meter_limiter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Update the predictor with one accepted event; a frame end yields a report
    function automatic void predict_frame_report(input logic kind, input logic [TIME_W-1:0] now,
                                                 output bit has_report,
                                                 output frame_report_t rep);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] elapsed;
        logic [IVAL_W-1:0] ival;
        longint unsigned   ival_sum;
        longint unsigned   rate;
        int unsigned       budget;
        int                i;
        has_report = 1'b0;
        rep = '0;
        if (kind == KIND_BEGIN)
        begin
            begin_ms = now;
            return;
        end
        span = seen_end ? now - last_end_ms : '0;
        ival = (span > 32'd65535) ? 16'hFFFF : span[IVAL_W-1:0];
        last_end_ms = now;
        seen_end = 1'b1;
        ival_ring[ring_wr] = ival;
        ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
        if (ring_fill < WINDOW)
            ring_fill++;

        // Average over the filled part of the ring
        ival_sum = 0;
        for (i = 0; i < ring_fill; i++)
            ival_sum += ival_ring[i];
        if (ival_sum == 0)
            rate = RATE_IDLE_Q8;
        else
            rate = (RATE_SCALE * ring_fill) / ival_sum;
        if (rate > RATE_CEIL_Q8)
            rate = RATE_CEIL_Q8;

        // Delay owed against the frame budget
        budget = MS_IN_S / ((fps_limit == 0) ? 1 : fps_limit);
        elapsed = now - begin_ms;
        rep.fps_q8 = rate[FPS_W-1:0];
        rep.delay_ms = (budget > elapsed) ? DELAY_W'(budget - elapsed) : '0;
        rep.frame_time_ms = ival;
        has_report = 1'b1;
    endfunction

    task automatic add_event(input logic kind, input logic [TIME_W-1:0] now);
        stim_step_t s;
        s.op = STEP_EVENT;
        s.kind = kind;
        s.now_ms = now;
        s.max_fps = '0;
        step_q.push_back(s);
        n_events++;
    endtask

    task automatic add_config(input logic [MAXFPS_W-1:0] value);
        stim_step_t s;
        s.op = STEP_CONFIG;
        s.kind = KIND_BEGIN;
        s.now_ms = '0;
        s.max_fps = value;
        step_q.push_back(s);
    endtask

    task automatic add_drain();
        stim_step_t s;
        s.op = STEP_DRAIN;
        s.kind = KIND_BEGIN;
        s.now_ms = '0;
        s.max_fps = '0;
        step_q.push_back(s);
    endtask

    // Driver: events, max_fps writes and drain pauses from the step queue
    always @(posedge clk or negedge rst_n)
    begin
        logic                nx_valid;
        logic [TIME_W-1:0]   nx_data;
        logic                nx_user;
        logic                nx_we;
        logic [MAXFPS_W-1:0] nx_wdata;
        bit                  got;
        frame_report_t       rep;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            cfg_we    <= 1'b0;
            cfg_wdata <= '0;
        end
        else
        begin
            nx_valid = s_tvalid;
            nx_data  = s_tdata;
            nx_user  = s_tuser;
            nx_we    = 1'b0;
            nx_wdata = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                predict_frame_report(s_tuser, s_tdata, got, rep);
                if (got)
                    report_q.push_back(rep);
                sent_cnt++;
                nx_valid = 1'b0;
            end
            if (!nx_valid && step_q.size() != 0)
            begin
                unique case (step_q[0].op)
                    STEP_DRAIN:
                    begin
                        if (report_q.size() == 0)
                            void'(step_q.pop_front());
                    end
                    STEP_CONFIG:
                    begin
                        // block must be idle: no report owed, then a quiet stretch
                        if (report_q.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt < SETTLE_CYCLES)
                            settle_cnt++;
                        else
                        begin
                            nx_we = 1'b1;
                            nx_wdata = step_q[0].max_fps;
                            fps_limit = step_q[0].max_fps;
                            settle_cnt = 0;
                            void'(step_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if ((sent_cnt >= 900 && sent_cnt < 1250) ||
                            $urandom_range(0, 99) >= IDLE_PCT)
                        begin
                            nx_valid = 1'b1;
                            nx_data = step_q[0].now_ms;
                            nx_user = step_q[0].kind;
                            void'(step_q.pop_front());
                        end
                    end
                endcase
            end
            s_tvalid  <= nx_valid;
            s_tdata   <= nx_data;
            s_tuser   <= nx_user;
            cfg_we    <= nx_we;
            cfg_wdata <= nx_wdata;
        end
    end

    // Monitor: check each report transfer and pace m_tready
    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t exp_rep;
        int            hold_cnt;
        bit            stall_done;
        logic          rdy;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt = 0;
            stall_done = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_cnt++;
                if (report_q.size() == 0)
                begin
                    $error("unexpected report transfer: m_tdata=%h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    exp_rep = report_q.pop_front();
                    if (m_tdata[21:0] !== exp_rep.fps_q8)
                    begin
                        $error("fps_q8 mismatch: expected %0d, actual %0d",
                               exp_rep.fps_q8, m_tdata[21:0]);
                        err_cnt++;
                    end
                    if (m_tdata[31:22] !== exp_rep.delay_ms)
                    begin
                        $error("delay_ms mismatch: expected %0d, actual %0d",
                               exp_rep.delay_ms, m_tdata[31:22]);
                        err_cnt++;
                    end
                    if (m_tdata[47:32] !== exp_rep.frame_time_ms)
                    begin
                        $error("frame_time_ms mismatch: expected %0d, actual %0d",
                               exp_rep.frame_time_ms, m_tdata[47:32]);
                        err_cnt++;
                    end
                end
            end

            // one long hold-off so the block backs up into its input
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (!stall_done && got_cnt >= 200)
            begin
                stall_done = 1'b1;
                hold_cnt = STALL_CYCLES;
                rdy = 1'b0;
            end
            else if (got_cnt >= 500 && got_cnt < 640)
                rdy = 1'b1;
            else
                rdy = ($urandom_range(0, 99) >= IDLE_PCT);
            m_tready <= rdy;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int                unsigned phase_fps[8];
        int                unsigned bud;
        int                p;
        int                r;
        int                stop_at;
        bit                drained;
        logic [TIME_W-1:0] t;

        ring_wr = 0;
        ring_fill = 0;
        last_end_ms = '0;
        seen_end = 1'b0;
        begin_ms = '0;
        fps_limit = 10'd60;
        foreach (ival_ring[i])
            ival_ring[i] = '0;

        // Directed: first end with no begin, short and late frames, long and wrapped spans
        add_event(KIND_END, 32'd100);
        add_event(KIND_BEGIN, 32'd200);
        add_event(KIND_END, 32'd205);
        add_event(KIND_BEGIN, 32'd210);
        add_event(KIND_END, 32'd210);
        add_event(KIND_BEGIN, 32'd300);
        add_event(KIND_END, 32'd400);
        add_event(KIND_BEGIN, 32'hFFFF_FFF8);
        add_event(KIND_END, 32'h0000_0004);
        add_event(KIND_END, 32'h0001_0005);
        add_event(KIND_BEGIN, 32'hFFFF_FFFF);
        add_event(KIND_END, 32'hFFFF_FFFF);
        add_event(KIND_BEGIN, 32'h0000_0000);
        add_event(KIND_END, 32'h0000_000A);
        // max_fps extremes, including zero and the 10-bit top of 1023
        add_config(10'd1);
        add_event(KIND_BEGIN, 32'd1000);
        add_event(KIND_END, 32'd1001);
        add_config(10'd0);
        add_event(KIND_BEGIN, 32'd1010);
        add_event(KIND_END, 32'd1010);
        add_config(10'd1023);
        add_event(KIND_BEGIN, 32'd1020);
        add_event(KIND_END, 32'd1020);
        add_config(10'd1000);
        add_event(KIND_BEGIN, 32'd1030);
        add_event(KIND_END, 32'd1030);

        // Random phases, one max_fps setting each
        phase_fps[0] = 1000;
        phase_fps[1] = 7;
        phase_fps[2] = 60;
        phase_fps[3] = 0;
        phase_fps[4] = 1023;
        phase_fps[5] = 1;
        phase_fps[6] = $urandom_range(1, 1000);
        phase_fps[7] = 144;
        t = $urandom;
        drained = 1'b0;
        for (p = 0; p < 8; p++)
        begin
            add_config(phase_fps[p][MAXFPS_W-1:0]);
            bud = MS_IN_S / ((phase_fps[p] == 0) ? 1 : phase_fps[p]);
            stop_at = n_events + 235;
            while (n_events < stop_at)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    // noise: any kind at any timestamp
                    t = $urandom;
                    add_event(1'($urandom_range(0, 1)), t);
                end
                else
                begin
                    // well-formed frame, sometimes with its begin missing
                    t += $urandom_range(0, 3);
                    if (r >= 15)
                        add_event(KIND_BEGIN, t);
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        t += $urandom_range(0, bud + 2);
                    else if (r < 88)
                        t += $urandom_range(0, 20);
                    else if (r < 94)
                        t += $urandom_range(65000, 70000);
                    else
                        t += $urandom;
                    add_event(KIND_END, t);
                end
                if (p == 3 && !drained && n_events >= stop_at - 120)
                begin
                    add_drain();
                    drained = 1'b1;
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (step_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (err_cnt == 0 && report_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
